/* design/cqd_pkg.sv */
// Shared constants, types and helpers for the circular queue with dump.
package cqd_pkg;

  // Queue geometry
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int WORD_W = 32;
  localparam int CODE_W = 2;
  localparam int IN_W   = ((WORD_W + 7) / 8) * 8;
  localparam int OUT_W  = ((WORD_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [CODE_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DUMP = 2'd2
  } opcode_t;

  typedef enum logic [CODE_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Advance a ring index with wrap at DEPTH
  function automatic idx_t next_idx(input idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

/* design/circular_queue_with_dump.sv */
// Top level of the circular queue with dump: control, indexes and output register.
//
// Usage:
//   Input stream (s_*): each transaction carries an opcode (enqueue, dequeue,
//   dump) on s_tuser and a signed 32-bit word on s_tdata used only by enqueue.
//   Output stream (m_*): each transaction carries a status on m_tuser and a
//   word on m_tdata; m_tlast marks the final result of one input item.
//   Enqueue gives one result in the cycle after acceptance (status ok or full).
//   Dequeue reads the oldest entry from the slot RAM; its result passes
//   through the RAM read register and then the output register. Dump reads
//   the entries oldest first, one per cycle when the receiver never stalls;
//   an empty queue gives one empty-status result. Opcode 3 gives no
//   result and changes nothing.
//   One item is in progress at a time: no new input is taken while a dequeue
//   or dump is still handing out words, each of which first passes the
//   registered read of the slot RAM.
//   Reset (rst, synchronous) empties the queue and drops any pending result;
//   slot contents are kept but are unreachable until rewritten.
//   When the receiver stalls, the output register holds its result and the
//   block stops taking input and stops advancing a dump until it drains.
module circular_queue_with_dump (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [31:0] push_value
  input  logic [cqd_pkg::IN_W-1:0]   s_tdata,
  // [1:0] opcode
  input  logic [cqd_pkg::CODE_W-1:0] s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [31:0] word_out
  output logic [cqd_pkg::OUT_W-1:0]  m_tdata,
  // [1:0] status
  output logic [cqd_pkg::CODE_W-1:0] m_tuser,
  output logic                       m_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_DUMP
  } state_t;

  state_t            state;
  cqd_pkg::idx_t     head;
  cqd_pkg::idx_t     tail;
  logic              is_empty;
  cqd_pkg::idx_t     ptr;
  logic              cur_fin;

  cqd_pkg::opcode_t  in_op;
  cqd_pkg::word_t    in_word;
  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              full;

  logic              wr_en;
  cqd_pkg::idx_t     wr_addr;
  logic              rd_en;
  cqd_pkg::idx_t     rd_addr;
  cqd_pkg::word_t    rd_data;

  // Decode the input transaction
  assign in_op    = cqd_pkg::opcode_t'(s_tuser);
  assign in_word  = cqd_pkg::word_t'(s_tdata[cqd_pkg::WORD_W-1:0]);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign full     = !is_empty && (cqd_pkg::next_idx(tail) == head);

  // Load the output register when a result is ready and the register is free
  assign out_load = (in_fire && ((in_op == cqd_pkg::OP_ENQ) ||
                                 ((in_op inside {cqd_pkg::OP_DEQ, cqd_pkg::OP_DUMP})
                                  && is_empty)))
                  || (((state == S_DEQ) || (state == S_DUMP)) && out_free);

  // Slot RAM access control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = is_empty ? '0 : cqd_pkg::next_idx(tail);
    rd_en   = 1'b0;
    rd_addr = head;
    if (in_fire) begin
      case (in_op)
        cqd_pkg::OP_ENQ:  wr_en = !full;
        cqd_pkg::OP_DEQ:  rd_en = !is_empty;
        cqd_pkg::OP_DUMP: rd_en = !is_empty;
        default:          ;
      endcase
    end else if (state == S_DUMP && out_free && !cur_fin) begin
      rd_en   = 1'b1;
      rd_addr = ptr;
    end
  end

  cqd_ram #(
    .ADDR_W (cqd_pkg::IDX_W),
    .DATA_W (cqd_pkg::WORD_W),
    .DEPTH  (cqd_pkg::DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, indexes and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
      m_tvalid <= 1'b0;
      cur_fin  <= 1'b0;
      ptr      <= '0;
    end else begin
      // Load a new result, or retire a taken transaction
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_op)
              cqd_pkg::OP_ENQ: begin
                m_tlast <= 1'b1;
                m_tdata <= '0;
                if (full) begin
                  m_tuser <= cqd_pkg::ST_FULL;
                end else begin
                  m_tuser  <= cqd_pkg::ST_OK;
                  tail     <= wr_addr;
                  if (is_empty) begin
                    head <= '0;
                  end
                  is_empty <= 1'b0;
                end
              end
              cqd_pkg::OP_DEQ: begin
                if (is_empty) begin
                  m_tlast <= 1'b1;
                  m_tdata <= '0;
                  m_tuser <= cqd_pkg::ST_EMPTY;
                end else begin
                  state <= S_DEQ;
                  if (head == tail) begin
                    head     <= '0;
                    tail     <= '0;
                    is_empty <= 1'b1;
                  end else begin
                    head <= cqd_pkg::next_idx(head);
                  end
                end
              end
              cqd_pkg::OP_DUMP: begin
                if (is_empty) begin
                  m_tlast <= 1'b1;
                  m_tdata <= '0;
                  m_tuser <= cqd_pkg::ST_EMPTY;
                end else begin
                  state   <= S_DUMP;
                  cur_fin <= (head == tail);
                  ptr     <= cqd_pkg::next_idx(head);
                end
              end
              default: ;
            endcase
          end
        end
        S_DEQ: begin
          // Hand out the word read at the old head
          if (out_free) begin
            m_tlast <= 1'b1;
            m_tdata <= rd_data;
            m_tuser <= cqd_pkg::ST_OK;
            state   <= S_IDLE;
          end
        end
        S_DUMP: begin
          // Emit the current word and advance to the next slot
          if (out_free) begin
            m_tlast <= cur_fin;
            m_tdata <= rd_data;
            m_tuser <= cqd_pkg::ST_OK;
            if (cur_fin) begin
              state <= S_IDLE;
            end else begin
              cur_fin <= (ptr == tail);
              ptr     <= cqd_pkg::next_idx(ptr);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An empty queue always has both indexes parked at zero
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0) && (tail == '0))
    else $error("empty queue with nonzero index");

  // A successful enqueue leaves the queue nonempty
  a_enq_fill: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_op == cqd_pkg::OP_ENQ && !full) |=> !is_empty)
    else $error("enqueue did not fill queue");

  // A dequeue of a stored word waits for the RAM read
  a_deq_wait: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_op == cqd_pkg::OP_DEQ && !is_empty) |=> state == S_DEQ)
    else $error("dequeue did not wait for read data");

  // Non-ok results carry a zero word
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != cqd_pkg::ST_OK) |-> (m_tdata == '0) && m_tlast)
    else $error("error status with nonzero word or open run");

  // Only dump words can leave a run open
  a_open_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == cqd_pkg::ST_OK))
    else $error("open run with non-ok status");

endmodule

/* design/cqd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cqd_ram #(
  parameter int ADDR_W = 3,
  parameter int DATA_W = 32,
  parameter int DEPTH  = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the circular queue with dump: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cqd_pkg::CODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 500;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * cqd_pkg::DEPTH + 24;

  typedef struct packed {
    cqd_pkg::status_t st;
    cqd_pkg::word_t   word;
    logic             last;
  } result_t;

  typedef struct {
    logic [cqd_pkg::CODE_W-1:0] op;
    cqd_pkg::word_t             val;
    bit                         typed;
    cqd_pkg::status_t           st;
    cqd_pkg::word_t             word;
  } row_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [cqd_pkg::IN_W-1:0]   s_tdata;
  logic [cqd_pkg::CODE_W-1:0] s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [cqd_pkg::OUT_W-1:0]  m_tdata;
  logic [cqd_pkg::CODE_W-1:0] m_tuser;
  logic                       m_tlast;

  // Ring image held by the predictor
  cqd_pkg::word_t ring_slots [cqd_pkg::DEPTH];
  cqd_pkg::idx_t  ring_head;
  cqd_pkg::idx_t  ring_tail;
  bit             ring_empty;

  result_t step_out [$];
  result_t due_results [$];
  row_t    dir_rows [$];
  int      errors;
  int      idle_cycles;

  circular_queue_with_dump u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic cqd_pkg::idx_t ring_step(input cqd_pkg::idx_t i);
    return cqd_pkg::idx_t'((int'(i) + 1) % cqd_pkg::DEPTH);
  endfunction

  // Apply one item to the ring image and collect the results it causes
  task automatic ring_apply(input logic [cqd_pkg::CODE_W-1:0] op, input cqd_pkg::word_t val);
    cqd_pkg::idx_t i;
    bit            fin;
    step_out.delete();
    case (op)
      cqd_pkg::OP_ENQ: begin
        if (!ring_empty && ring_step(ring_tail) == ring_head) begin
          step_out.push_back('{cqd_pkg::ST_FULL, '0, 1'b1});
        end else begin
          if (ring_empty) begin
            ring_head  = '0;
            ring_tail  = '0;
            ring_empty = 1'b0;
          end else begin
            ring_tail = ring_step(ring_tail);
          end
          ring_slots[ring_tail] = val;
          step_out.push_back('{cqd_pkg::ST_OK, '0, 1'b1});
        end
      end
      cqd_pkg::OP_DEQ: begin
        if (ring_empty) begin
          step_out.push_back('{cqd_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          step_out.push_back('{cqd_pkg::ST_OK, ring_slots[ring_head], 1'b1});
          if (ring_head == ring_tail) begin
            ring_head  = '0;
            ring_tail  = '0;
            ring_empty = 1'b1;
          end else begin
            ring_head = ring_step(ring_head);
          end
        end
      end
      cqd_pkg::OP_DUMP: begin
        if (ring_empty) begin
          step_out.push_back('{cqd_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          i = ring_head;
          for (int k = 0; k < cqd_pkg::DEPTH; k++) begin
            fin = (i == ring_tail);
            step_out.push_back('{cqd_pkg::ST_OK, ring_slots[i], fin});
            if (fin) break;
            i = ring_step(i);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [cqd_pkg::CODE_W-1:0] op, input cqd_pkg::word_t val,
                         input bit typed, input cqd_pkg::status_t st,
                         input cqd_pkg::word_t word);
    dir_rows.push_back('{op, val, typed, st, word});
  endtask

  // Drive one transaction after a gap; entered and left just after a falling edge
  task automatic send_item(input row_t r, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.val;
    s_tuser  <= r.op;
    do @(posedge clk); while (!s_tready);
    ring_apply(r.op, r.val);
    if (r.typed && step_out.size() != 0) begin
      due_results.push_back('{r.st, r.word, 1'b1});
    end else begin
      foreach (step_out[k]) due_results.push_back(step_out[k]);
    end
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has arrived
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    row_t r;
    int   n_real;
    bit   fill_phase;
    bit   calm;
    int   pick;
    int   gap;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    errors     = 0;
    ring_head  = '0;
    ring_tail  = '0;
    ring_empty = 1'b1;
    foreach (ring_slots[k]) ring_slots[k] = '0;

    // Directed: empty queue, extremes, full, wrap and the unused opcode
    add_row(cqd_pkg::OP_DEQ,  32'sh1234_5678, 1, cqd_pkg::ST_EMPTY, '0);
    add_row(cqd_pkg::OP_DUMP, '0,             1, cqd_pkg::ST_EMPTY, '0);
    add_row(OP_UNUSED,        '1,             0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_ENQ,  32'sh7FFF_FFFF, 1, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_ENQ,  32'sh8000_0000, 1, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_DUMP, '1,             0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_DEQ,  '0,             1, cqd_pkg::ST_OK,    32'sh7FFF_FFFF);
    add_row(cqd_pkg::OP_DEQ,  '1,             1, cqd_pkg::ST_OK,    32'sh8000_0000);
    add_row(cqd_pkg::OP_DEQ,  '0,             1, cqd_pkg::ST_EMPTY, '0);
    for (int k = 0; k < cqd_pkg::DEPTH; k++) begin
      add_row(cqd_pkg::OP_ENQ,
              cqd_pkg::word_t'(32'h2468_ACE1 * (k + 1)) ^ cqd_pkg::word_t'({32{k[0]}}),
              0, cqd_pkg::ST_OK, '0);
    end
    add_row(cqd_pkg::OP_ENQ,  '1,             1, cqd_pkg::ST_FULL,  '0);
    add_row(cqd_pkg::OP_DUMP, '0,             0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_DEQ,  '0,             0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_ENQ,  32'sh1234_5678, 0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_DUMP, '0,             0, cqd_pkg::ST_OK,    '0);
    add_row(OP_UNUSED,        '0,             0, cqd_pkg::ST_OK,    '0);
    add_row(cqd_pkg::OP_DEQ,  '0,             0, cqd_pkg::ST_OK,    '0);

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k], $urandom_range(0, 15));
    end
    hold_until_drained();

    // Random: alternate fill-biased and drain-biased phases
    n_real     = 0;
    fill_phase = 1'b1;
    calm       = 1'b0;
    while (n_real < RAND_ITEMS) begin
      if (n_real % 40 == 0) begin
        fill_phase = ~fill_phase;
        calm       = ($urandom_range(0, 3) == 0);
      end
      if (n_real == RAND_ITEMS / 2) begin
        hold_until_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        r.op = OP_UNUSED;
      end else if (pick < (fill_phase ? 70 : 30)) begin
        r.op = cqd_pkg::OP_ENQ;
      end else if (pick < 85) begin
        r.op = cqd_pkg::OP_DEQ;
      end else begin
        r.op = cqd_pkg::OP_DUMP;
      end
      case ($urandom_range(0, 11))
        0:       r.val = '0;
        1:       r.val = '1;
        2:       r.val = 32'sh7FFF_FFFF;
        3:       r.val = 32'sh8000_0000;
        default: r.val = cqd_pkg::word_t'($urandom);
      endcase
      r.typed = 1'b0;
      r.st    = cqd_pkg::ST_OK;
      r.word  = '0;
      gap = calm ? 0 : $urandom_range(0, 15);
      send_item(r, gap);
      if (r.op != OP_UNUSED) n_real++;
    end
    s_tvalid <= 1'b0;

    // Wait for the last results, then let the block settle
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Receiver: random stall before each result, with calm stretches
  initial begin
    int  n_seen;
    bit  calm;
    int  stall;
    m_tready = 1'b0;
    n_seen   = 0;
    calm     = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n_seen % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_seen++;
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t          want;
    cqd_pkg::status_t got_st;
    cqd_pkg::word_t   got_word;
    if (!rst && m_tvalid && m_tready) begin
      got_st   = cqd_pkg::status_t'(m_tuser);
      got_word = cqd_pkg::word_t'(m_tdata[cqd_pkg::WORD_W-1:0]);
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d word %h last %0b", got_st, got_word, m_tlast);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (got_st !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, got_st);
          errors++;
        end
        if (got_word !== want.word) begin
          $error("word_out: expected %h, got %h", want.word, got_word);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule
